### rtl/core/rpn_pkg.sv
package rpn_pkg;

    localparam int StackDepth = 16;
    localparam int AddrW      = $clog2(StackDepth);
    localparam int CountW     = $clog2(StackDepth + 1);

    typedef enum logic [3:0] {
        CMD_PUSH  = 4'd0,
        CMD_PORT  = 4'd1,
        CMD_TOP   = 4'd2,
        CMD_DUMP  = 4'd3,
        CMD_SWAP  = 4'd4,
        CMD_NEG   = 4'd5,
        CMD_SUM   = 4'd6,
        CMD_ADD   = 4'd7,
        CMD_SUB   = 4'd8,
        CMD_MUL   = 4'd9,
        CMD_DIV   = 4'd10,
        CMD_CLEAR = 4'd11,
        CMD_HALT  = 4'd12
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_DIVZERO   = 2'd3
    } t_status;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] operand;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         port;
        logic signed [31:0] value;
        logic [1:0]         status;
        logic               last;
    } t_out_item;

    // ALU operation select
    typedef enum logic [2:0] {
        ALU_PASS,
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_NEG
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DIVFIN,
        S_WR,
        S_WR2,
        S_SCAN,
        S_SCANWT,
        S_EMIT
    } t_state;

    // divider control and status
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quot;
    } t_div_sts;

endpackage

### rtl/core/rpn_div.sv
module rpn_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpn_pkg::t_div_ctl i_ctl,
    input  logic [31:0]       i_num,
    input  logic [31:0]       i_den,
    output rpn_pkg::t_div_sts o_sts
);
    import rpn_pkg::*;

    logic [31:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_trial;
    logic [32:0] w_sh;

    // restoring divide on magnitudes, one quotient bit per cycle
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh    = {r_rem[31:0], r_quo[31]};
        w_trial = w_sh - {1'b0, r_den};
        if (i_ctl.start) begin
            n_quo  = i_num[31] ? (32'd0 - i_num) : i_num;
            n_den  = i_den[31] ? (32'd0 - i_den) : i_den;
            n_neg  = i_num[31] ^ i_den[31];
            n_rem  = '0;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                n_rem = w_trial;
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_sts.quot = r_neg ? (32'd0 - r_quo) : r_quo;

endmodule

### rtl/core/rpn_alu.sv
module rpn_alu (
    input  logic             i_clk,
    input  rpn_pkg::t_alu_op i_op,
    input  logic [31:0]      i_a,
    input  logic [31:0]      i_b,
    output logic [31:0]      o_res
);
    import rpn_pkg::*;

    logic [31:0] r_res;
    logic [31:0] n_res;

    // shared add/sub/mul/neg unit, registered output
    always_comb begin
        case (i_op)
            ALU_ADD: n_res = i_a + i_b;
            ALU_SUB: n_res = i_a - i_b;
            ALU_MUL: n_res = i_a * i_b;
            ALU_NEG: n_res = 32'd0 - i_a;
            default: n_res = i_a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

### rtl/core/rpn_stack_calculator_unit.sv
// rpn_stack_calculator_unit: stack calculator under a small sequencer.
// Div uses a bit-serial divider; dump/sum read the stack one entry at a
// time (one memory read port). One item at a time.
// Reset: synchronous active low; clears count, port, halt flag and control.
module rpn_stack_calculator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rpn_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output rpn_pkg::t_out_item o_data
);
    import rpn_pkg::*;

    logic [31:0] mem [StackDepth];
    logic [31:0] r_rdata;
    logic [AddrW-1:0] w_raddr;
    logic             w_we;
    logic [AddrW-1:0] w_waddr;
    logic [31:0]      w_wdata;

    t_state      r_state, n_state;
    logic [CountW-1:0] r_count, n_count;
    logic [7:0]  r_port, n_port;
    logic        r_halt, n_halt;
    t_cmd        r_cmd, n_cmd;
    logic [31:0] r_top, n_top;
    logic [31:0] r_next, n_next;
    logic [31:0] r_acc, n_acc;
    logic [CountW-1:0] r_idx, n_idx;
    logic        r_ovalid, n_ovalid;
    t_out_item   r_odata, n_odata;

    t_alu_op     w_op;
    logic [31:0] w_alu;
    t_div_ctl    w_dctl;
    t_div_sts    w_dsts;
    logic        w_ofree;
    logic        w_accept;

    rpn_alu u_alu (
        .i_clk (i_clk),
        .i_op  (w_op),
        .i_a   (r_top),
        .i_b   (r_next),
        .o_res (w_alu)
    );

    rpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dctl),
        .i_num   (r_next),
        .i_den   (r_top),
        .o_sts   (w_dsts)
    );

    // stack memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    assign w_ofree  = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || !w_ofree;
    assign w_accept = i_valid && !o_stall;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_port   = r_port;
        n_halt   = r_halt;
        n_cmd    = r_cmd;
        n_top    = r_top;
        n_next   = r_next;
        n_acc    = r_acc;
        n_idx    = r_idx;
        n_ovalid = r_ovalid && i_stall;
        n_odata  = r_odata;
        w_raddr  = r_idx[AddrW-1:0] - AddrW'(1);
        w_we     = 1'b0;
        w_waddr  = r_count[AddrW-1:0];
        w_wdata  = i_data.operand;
        w_op     = ALU_PASS;
        w_dctl.start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept && !r_halt) begin
                    n_cmd = t_cmd'(i_data.command);
                    n_idx = r_count;
                    n_acc = '0;
                    case (i_data.command)
                        CMD_PUSH: begin
                            if (r_count == CountW'(StackDepth)) begin
                                n_ovalid = 1'b1;
                                n_odata  = '{r_port, 32'sd0, ST_OVERFLOW, 1'b1};
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + CountW'(1);
                            end
                        end
                        CMD_PORT:  n_port = i_data.operand[7:0];
                        CMD_CLEAR: n_count = '0;
                        CMD_HALT:  n_halt = 1'b1;
                        CMD_DUMP, CMD_SUM: begin
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_TOP, CMD_NEG: begin
                            if (r_count == '0) begin
                                n_ovalid = 1'b1;
                                n_odata  = '{r_port, 32'sd0, ST_UNDERFLOW, 1'b1};
                            end else begin
                                n_state = S_RD1;
                            end
                        end
                        CMD_SWAP, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                            if (r_count < CountW'(2)) begin
                                n_ovalid = 1'b1;
                                n_odata  = '{r_port, 32'sd0, ST_UNDERFLOW, 1'b1};
                            end else begin
                                n_state = S_RD1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // read top (address count-1)
            S_RD1: begin
                w_raddr = r_count[AddrW-1:0] - AddrW'(1);
                n_state = S_RD2;
            end
            S_RD2: begin
                w_raddr = r_count[AddrW-1:0] - AddrW'(2);
                n_top   = r_rdata;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_next = r_rdata;
                case (r_cmd)
                    CMD_TOP: begin
                        if (w_ofree) begin
                            n_ovalid = 1'b1;
                            n_odata  = '{r_port, r_top, ST_OK, 1'b1};
                            n_state  = S_IDLE;
                        end
                    end
                    CMD_SWAP: begin
                        w_we    = 1'b1;
                        w_waddr = r_count[AddrW-1:0] - AddrW'(1);
                        w_wdata = r_rdata;
                        n_state = S_WR2;
                    end
                    CMD_DIV: begin
                        if (r_top == '0) begin
                            if (w_ofree) begin
                                n_ovalid = 1'b1;
                                n_odata  = '{r_port, 32'sd0, ST_DIVZERO, 1'b1};
                                n_state  = S_IDLE;
                            end
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                    default: n_state = S_MUL;
                endcase
            end
            // ALU pass with operands latched
            S_MUL: begin
                case (r_cmd)
                    CMD_ADD: w_op = ALU_ADD;
                    CMD_SUB: w_op = ALU_SUB;
                    CMD_MUL: w_op = ALU_MUL;
                    CMD_NEG: w_op = ALU_NEG;
                    default: w_op = ALU_PASS;
                endcase
                n_state = S_WR;
            end
            S_DIV: begin
                w_dctl.start = 1'b1;
                n_state      = S_DIVFIN;
            end
            S_DIVFIN: begin
                if (w_dsts.done) begin
                    n_acc   = w_dsts.quot;
                    n_state = S_EMIT;
                end
            end
            S_WR: begin
                if (r_cmd == CMD_NEG) begin
                    w_we    = 1'b1;
                    w_waddr = r_count[AddrW-1:0] - AddrW'(1);
                    w_wdata = w_alu;
                    n_state = S_IDLE;
                end else begin
                    n_acc   = w_alu;
                    n_state = S_EMIT;
                end
            end
            S_WR2: begin
                w_we    = 1'b1;
                w_waddr = r_count[AddrW-1:0] - AddrW'(2);
                w_wdata = r_top;
                n_state = S_IDLE;
            end
            // binary op: pop, write new top, emit
            S_EMIT: begin
                if (w_ofree) begin
                    w_we     = 1'b1;
                    w_waddr  = r_count[AddrW-1:0] - AddrW'(2);
                    w_wdata  = r_acc;
                    n_count  = r_count - CountW'(1);
                    n_ovalid = 1'b1;
                    n_odata  = '{r_port, r_acc, ST_OK, 1'b1};
                    n_state  = S_IDLE;
                end
            end
            // dump/sum: read entry idx-1, then emit
            S_SCAN: begin
                n_state = S_SCANWT;
            end
            S_SCANWT: begin
                if (w_ofree) begin
                    n_ovalid = 1'b1;
                    if (r_cmd == CMD_SUM) begin
                        n_acc   = r_acc + r_rdata;
                        n_odata = '{r_port, r_acc + r_rdata, ST_OK,
                                    r_idx == CountW'(1)};
                    end else begin
                        n_odata = '{r_port, r_rdata, ST_OK, r_idx == CountW'(1)};
                    end
                    n_idx   = r_idx - CountW'(1);
                    n_state = (r_idx == CountW'(1)) ? S_IDLE : S_SCAN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_top   <= n_top;
        r_next  <= n_next;
        r_acc   <= n_acc;
        r_idx   <= n_idx;
        r_odata <= n_odata;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_port   <= '0;
            r_halt   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_port   <= n_port;
            r_halt   <= n_halt;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(StackDepth))
        else $error("stack count out of range");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("output dropped under stall");
`endif

endmodule

### tb/tb_top.sv
module tb_top;
    import rpn_pkg::*;

    localparam int LIMIT = 400000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_data;

    always #1 i_clk = ~i_clk;

    rpn_stack_calculator_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    // calculator shadow state
    logic [31:0] calc_stack [StackDepth];
    int          calc_depth;
    logic [7:0]  calc_port;
    logic        calc_halted;

    t_out_item   pending_results [$];
    int          mismatch_count;
    int          cycle_count;
    logic        timed_out;
    int          i;
    int          stall_left = 0;

    // directed rows: fixed result checked only where chk is set
    typedef struct {
        logic [3:0]  cmd;
        logic [31:0] opnd;
        logic        chk;
        t_out_item   res;
    } t_row;

    function automatic t_out_item make_result(logic [31:0] v, t_status s, logic l);
        t_out_item r;
        r.port   = calc_port;
        r.value  = v;
        r.status = s;
        r.last   = l;
        return r;
    endfunction

    function automatic logic [31:0] trunc_divide(logic [31:0] num, logic [31:0] den);
        logic [31:0] un, ud, q;
        un = num[31] ? -num : num;
        ud = den[31] ? -den : den;
        q  = un / ud;
        return (num[31] != den[31]) ? -q : q;
    endfunction

    // advance the shadow calculator by one command, queue what it emits
    task automatic predict_command(input logic [3:0] cmd, input logic [31:0] opnd);
        logic [31:0] tv, nv, acc;
        int k;
        if (calc_halted) return;
        case (cmd)
            CMD_PUSH: begin
                if (calc_depth >= StackDepth) begin
                    pending_results.push_back(make_result(0, ST_OVERFLOW, 1'b1));
                end else begin
                    calc_stack[calc_depth] = opnd;
                    calc_depth++;
                end
            end
            CMD_PORT: calc_port = opnd[7:0];
            CMD_TOP: begin
                if (calc_depth < 1)
                    pending_results.push_back(make_result(0, ST_UNDERFLOW, 1'b1));
                else
                    pending_results.push_back(
                        make_result(calc_stack[calc_depth-1], ST_OK, 1'b1));
            end
            CMD_DUMP, CMD_SUM: begin
                acc = 0;
                for (k = calc_depth; k > 0; k--) begin
                    tv = calc_stack[k-1];
                    if (cmd == CMD_SUM) begin
                        acc = acc + tv;
                        tv = acc;
                    end
                    pending_results.push_back(make_result(tv, ST_OK, k == 1));
                end
            end
            CMD_SWAP: begin
                if (calc_depth < 2) begin
                    pending_results.push_back(make_result(0, ST_UNDERFLOW, 1'b1));
                end else begin
                    tv = calc_stack[calc_depth-1];
                    calc_stack[calc_depth-1] = calc_stack[calc_depth-2];
                    calc_stack[calc_depth-2] = tv;
                end
            end
            CMD_NEG: begin
                if (calc_depth < 1)
                    pending_results.push_back(make_result(0, ST_UNDERFLOW, 1'b1));
                else
                    calc_stack[calc_depth-1] = -calc_stack[calc_depth-1];
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                if (calc_depth < 2) begin
                    pending_results.push_back(make_result(0, ST_UNDERFLOW, 1'b1));
                end else begin
                    tv = calc_stack[calc_depth-1];
                    nv = calc_stack[calc_depth-2];
                    if (cmd == CMD_DIV && tv == 0) begin
                        pending_results.push_back(make_result(0, ST_DIVZERO, 1'b1));
                    end else begin
                        case (cmd)
                            CMD_ADD: acc = tv + nv;
                            CMD_SUB: acc = tv - nv;
                            CMD_MUL: acc = tv * nv;
                            default: acc = trunc_divide(nv, tv);
                        endcase
                        calc_depth--;
                        calc_stack[calc_depth-1] = acc;
                        pending_results.push_back(make_result(acc, ST_OK, 1'b1));
                    end
                end
            end
            CMD_CLEAR: calc_depth = 0;
            CMD_HALT:  calc_halted = 1'b1;
            default: ;
        endcase
    endtask

    // random gap length: mostly short, sometimes long
    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one command and predict it on acceptance
    task automatic send_command(input logic [3:0] cmd, input logic [31:0] opnd);
        int g;
        g = gap_length();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{command: cmd, operand: opnd};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_command(cmd, opnd);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return $urandom_range(0, 9);
            default: return $urandom;
        endcase
    endfunction

    // receiver side: random stall bursts, compare each transfer
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transfer: %p", o_data);
                end else begin
                    want = pending_results.pop_front();
                    if (o_data.port !== want.port || o_data.value !== want.value ||
                        o_data.status !== want.status || o_data.last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch: expected %p got %p", want, o_data);
                    end
                end
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else if ($urandom_range(0, 99) < 30) begin
                stall_left = gap_length();
                i_stall <= (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // cycle watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("rpn_stack_calculator_unit test failed");
            $finish;
        end
    end

    t_row rows [$];

    initial begin
        int w;
        int n;
        int depth_goal;
        logic [3:0] c;
        mismatch_count = 0;
        cycle_count = 0;
        calc_depth = 0;
        calc_port = 0;
        calc_halted = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: errors on empty stack, extremes, every command but halt
        rows = '{
            '{CMD_TOP,   32'd0,        1, '{8'd0, 32'd0, ST_UNDERFLOW, 1'b1}},
            '{CMD_SWAP,  32'd0,        1, '{8'd0, 32'd0, ST_UNDERFLOW, 1'b1}},
            '{CMD_NEG,   32'd0,        1, '{8'd0, 32'd0, ST_UNDERFLOW, 1'b1}},
            '{CMD_DUMP,  32'd0,        0, '0},
            '{CMD_PORT,  32'hffff_ffa5, 0, '0},
            '{CMD_PUSH,  32'h8000_0000, 0, '0},
            '{CMD_ADD,   32'd0,        1, '{8'ha5, 32'd0, ST_UNDERFLOW, 1'b1}},
            '{CMD_PUSH,  32'hffff_ffff, 0, '0},
            '{CMD_DIV,   32'd0,        1, '{8'ha5, 32'h8000_0000, ST_OK, 1'b1}},
            '{CMD_PUSH,  32'd0,        0, '0},
            '{CMD_DIV,   32'd0,        1, '{8'ha5, 32'd0, ST_DIVZERO, 1'b1}},
            '{CMD_PUSH,  32'h7fff_ffff, 0, '0},
            '{CMD_SWAP,  32'd0,        0, '0},
            '{CMD_NEG,   32'd0,        0, '0},
            '{CMD_SUM,   32'd0,        0, '0},
            '{CMD_MUL,   32'd0,        0, '0},
            '{CMD_PUSH,  32'd7,        0, '0},
            '{CMD_SUB,   32'd0,        0, '0},
            '{CMD_PUSH,  32'hffff_fff9, 0, '0},
            '{CMD_ADD,   32'd0,        0, '0},
            '{4'd13,     32'd0,        0, '0},
            '{4'd15,     32'hffff_ffff, 0, '0},
            '{CMD_DUMP,  32'd0,        0, '0},
            '{CMD_TOP,   32'd0,        0, '0},
            '{CMD_CLEAR, 32'd0,        0, '0}
        };
        foreach (rows[r]) begin
            w = pending_results.size();
            send_command(rows[r].cmd, rows[r].opnd);
            if (rows[r].chk && pending_results.size() == w + 1 &&
                pending_results[w] !== rows[r].res) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("directed row %0d: table %p model %p", r, rows[r].res,
                             pending_results[w]);
            end
        end

        // overflow: fill the stack then push once more
        for (i = 0; i <= StackDepth; i++) send_command(CMD_PUSH, random_value());
        send_command(CMD_DUMP, 0);
        send_command(CMD_SUM, 0);
        send_command(CMD_CLEAR, 0);

        // random: mostly build a stack then operate on it
        n = 0;
        while (n < 340) begin
            depth_goal = $urandom_range(0, 99) < 10 ? StackDepth : $urandom_range(0, 5);
            while (calc_depth < depth_goal && n < 340) begin
                send_command(CMD_PUSH, random_value());
                n++;
            end
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 19))
                    0:       c = CMD_PUSH;
                    1:       c = CMD_PORT;
                    2:       c = CMD_TOP;
                    3:       c = CMD_DUMP;
                    4:       c = CMD_SWAP;
                    5:       c = CMD_NEG;
                    6:       c = CMD_SUM;
                    7, 8:    c = CMD_ADD;
                    9, 10:   c = CMD_SUB;
                    11, 12:  c = CMD_MUL;
                    13, 14:  c = CMD_DIV;
                    15:      c = CMD_CLEAR;
                    16:      c = 4'($urandom_range(13, 15));
                    default: c = CMD_TOP;
                endcase
                send_command(c, random_value());
                n++;
            end
        end

        // halt, then everything after must be ignored
        send_command(CMD_PUSH, 32'd3);
        send_command(CMD_HALT, 0);
        send_command(CMD_TOP, 0);
        send_command(CMD_DUMP, 0);
        send_command(CMD_PUSH, 32'd1);
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("rpn_stack_calculator_unit test passed");
        end else begin
            $display("rpn_stack_calculator_unit test failed");
        end
        $finish;
    end

endmodule
